### src/flv_aac_to_adts_framer_defines.svh
// assertion macros shared by the framer checker
`ifndef FLV_AAC_TO_ADTS_FRAMER_DEFINES_SVH
`define FLV_AAC_TO_ADTS_FRAMER_DEFINES_SVH

// property checked on every clock edge outside reset
`define FLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define FLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/flvadts_pkg.sv
// shared constants and types for the flv aac to adts framer
package flvadts_pkg;

  localparam int HDR_BYTES = 7;

  localparam logic [3:0] FMT_AAC         = 4'd10;
  localparam logic [7:0] PKT_SEQ_HEADER  = 8'd0;
  localparam logic [7:0] PKT_RAW_FRAME   = 8'd1;

  // fixed adts header bytes: sync word, mpeg-4, layer 0, no crc
  localparam logic [7:0] ADTS_SYNC_HI    = 8'hFF;
  localparam logic [7:0] ADTS_SYNC_LO    = 8'hF1;
  localparam logic [4:0] FULLNESS_HI     = 5'h1F;
  localparam logic [7:0] ADTS_TAIL       = 8'hFC;
  localparam logic [12:0] FLEN_EXTRA     = 13'd5;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

  // what one tag byte produces
  typedef struct packed {
    logic       emit_hdr;   // seven-byte header burst
    logic       emit_byte;  // single payload byte
    logic [7:0] data;       // payload byte
    logic       last;       // frame ends with this byte (or header byte 6)
    hdr_bytes_t hdr;        // header bytes, byte 0 in index 0
  } res_t;

endpackage

### src/flvadts_if.sv
// stream interfaces for tag body bytes in and adts bytes out
interface flvadts_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tag_byte;
  logic        first;
  logic [23:0] tag_len;

  modport source (output valid, tag_byte, first, tag_len, input ready);
  modport sink   (input valid, tag_byte, first, tag_len, output ready);
endinterface

interface flvadts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;

  modport source (output valid, out_byte, frame_last, input ready);
  modport sink   (input valid, out_byte, frame_last, output ready);
endinterface

### src/flvadts_parse.sv
// tag parser: per-tag state, stored aac config and adts header build
module flvadts_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          tag_byte,
  input  logic                first,
  input  logic [23:0]         tag_len,
  output flvadts_pkg::res_t   res
);
  import flvadts_pkg::*;

  logic [1:0]  profile_bits;
  logic [3:0]  rate_index;
  logic [2:0]  channel_count;
  logic [23:0] byte_position;
  logic [23:0] tag_length;
  logic        is_aac;
  logic [7:0]  packet_type;
  logic [7:0]  held_config_byte;

  logic        in_range;
  logic        at_pkt_byte;
  logic [12:0] flen;
  logic [23:0] pos_plus;

  // byte is inside the current tag body
  assign in_range    = (byte_position != 24'd0) && (byte_position < tag_length);
  assign at_pkt_byte = (byte_position == 24'd1);
  assign pos_plus    = byte_position + 24'd1;
  assign flen        = tag_length[12:0] + FLEN_EXTRA;

  // result for the byte at hand
  always_comb begin
    res = '0;
    res.data   = tag_byte;
    res.hdr[0] = ADTS_SYNC_HI;
    res.hdr[1] = ADTS_SYNC_LO;
    res.hdr[2] = {profile_bits, rate_index, 1'b0, channel_count[2]};
    res.hdr[3] = {channel_count[1:0], 4'b0000, flen[12:11]};
    res.hdr[4] = flen[10:3];
    res.hdr[5] = {flen[2:0], FULLNESS_HI};
    res.hdr[6] = ADTS_TAIL;
    if (!first && in_range && is_aac) begin
      if (at_pkt_byte) begin
        res.emit_hdr = (tag_byte == PKT_RAW_FRAME);
        res.last     = (tag_length == 24'd2);
      end else if (packet_type == PKT_RAW_FRAME) begin
        res.emit_byte = 1'b1;
        res.last      = (pos_plus == tag_length);
      end
    end
  end

  // per-tag tracking and sequence header capture
  always_ff @(posedge clk) begin
    if (rst) begin
      profile_bits     <= '0;
      rate_index       <= '0;
      channel_count    <= '0;
      byte_position    <= '0;
      tag_length       <= '0;
      is_aac           <= 1'b0;
      packet_type      <= '0;
      held_config_byte <= '0;
    end else if (step) begin
      if (first) begin
        tag_length       <= tag_len;
        is_aac           <= (tag_byte[7:4] == FMT_AAC);
        packet_type      <= '0;
        held_config_byte <= '0;
        byte_position    <= 24'd1;
      end else if (in_range) begin
        byte_position <= pos_plus;
        if (is_aac) begin
          if (at_pkt_byte) begin
            packet_type <= tag_byte;
          end else if (packet_type == PKT_SEQ_HEADER) begin
            if (byte_position == 24'd2) begin
              held_config_byte <= tag_byte;
            end else if (byte_position == 24'd3) begin
              profile_bits  <= held_config_byte[4:3] + 2'd3;
              rate_index    <= {held_config_byte[2:0], tag_byte[7]};
              channel_count <= tag_byte[5:3];
            end
          end
        end
      end
    end
  end

endmodule

### src/flv_aac_to_adts_framer.sv
// flv aac audio tag body to adts frame framer, top level
//
//   channel   dir  payload                      accepted when
//   tag_in    in   tag_byte, first, tag_len     tag_in.valid && tag_in.ready
//   adts_out  out  out_byte, frame_last         adts_out.valid && adts_out.ready
//
// one tag byte per cycle while the output is not stalled and no header burst is
// pending; a raw frame's packet type byte starts the seven-byte header burst, which
// holds the input stage. a byte passes the input register, then the output register.
// rst is synchronous; it clears the stored aac config and tag tracking.
// input register takes a byte while the output register is stalled.
module flv_aac_to_adts_framer (
  input  logic           clk,
  input  logic           rst,
  flvadts_in_if.sink     tag_in,
  flvadts_out_if.source  adts_out
);
  import flvadts_pkg::*;

  // input register
  logic        s1v;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic [23:0] s1_len;

  // output register and pending header bytes
  logic        ov;
  logic [7:0]  obyte;
  logic        olast;
  logic [2:0]  hdr_rem;
  logic [HDR_BYTES-2:0][7:0] hdr_buf;
  logic        hdr_last;

  logic        load_ok;
  logic        s1_adv;
  logic        in_xfer;
  res_t        res;

  assign load_ok = !ov || adts_out.ready;
  assign s1_adv  = s1v && (hdr_rem == 3'd0) && load_ok;
  assign in_xfer = tag_in.valid && tag_in.ready;

  assign tag_in.ready        = !s1v || s1_adv;
  assign adts_out.valid      = ov;
  assign adts_out.out_byte   = obyte;
  assign adts_out.frame_last = olast;

  flvadts_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_adv),
    .tag_byte (s1_byte),
    .first    (s1_first),
    .tag_len  (s1_len),
    .res      (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else if (in_xfer) begin
      s1v <= 1'b1;
    end else if (s1_adv) begin
      s1v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte  <= tag_in.tag_byte;
      s1_first <= tag_in.first;
      s1_len   <= tag_in.tag_len;
    end
  end

  // output register: header burst first, then payload bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      ov      <= 1'b0;
      hdr_rem <= '0;
    end else if (load_ok) begin
      if (hdr_rem != 3'd0) begin
        ov      <= 1'b1;
        hdr_rem <= hdr_rem - 3'd1;
      end else if (s1_adv && res.emit_hdr) begin
        ov      <= 1'b1;
        hdr_rem <= 3'(HDR_BYTES - 1);
      end else begin
        ov <= s1_adv && res.emit_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (hdr_rem != 3'd0) begin
        obyte   <= hdr_buf[0];
        olast   <= (hdr_rem == 3'd1) ? hdr_last : 1'b0;
        hdr_buf <= {8'h00, hdr_buf[HDR_BYTES-2:1]};
      end else if (s1_adv && res.emit_hdr) begin
        obyte    <= res.hdr[0];
        olast    <= 1'b0;
        hdr_buf  <= res.hdr[HDR_BYTES-1:1];
        hdr_last <= res.last;
      end else if (s1_adv && res.emit_byte) begin
        obyte <= res.data;
        olast <= res.last;
      end
    end
  end

endmodule

### src/flvadts_checker.sv
// port-level checker for the framer, bound to the top level
`include "flv_aac_to_adts_framer_defines.svh"

module flvadts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic out_stall;
  logic in_xfer;

  // output held back, input transfer
  assign out_stall = out_valid && !out_ready;
  assign in_xfer   = in_valid && in_ready;

  // reset leaves no result pending
  `FLV_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

  // a stalled result holds its byte and mark
  `FLV_ASSERT(a_out_hold, out_stall |=> out_valid && $stable({out_byte, out_last}), "stall not held")

  // with the output still stalled, a byte taken in during a stall fills the input stage
  `FLV_ASSERT(a_in_fill, out_stall && $past(out_stall && in_xfer) |-> !in_ready, "ready while full")

endmodule

bind flv_aac_to_adts_framer flvadts_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tag_in.valid),
  .in_ready  (tag_in.ready),
  .out_valid (adts_out.valid),
  .out_ready (adts_out.ready),
  .out_byte  (adts_out.out_byte),
  .out_last  (adts_out.frame_last)
);
